// ----- hw/rtl/cms_pkg.sv -----
// ----------------------------------------------------------------------------
// cms_pkg: shared constants and types of the count-min sketch
// Hash constants, counter limits, register map and the control bundle
// between the sequencer and the row hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

  // Row hash: h = h*33 + byte, 64 bits, seed 1934 + row
  localparam int HASH_W    = 64;
  localparam int SEED_BASE = 1934;
  localparam int SHIFT_MUL = 5;

  // Remainder unit takes this many hash bits per cycle
  localparam int DIGIT_BITS = 4;
  localparam int MOD_STEPS  = HASH_W / DIGIT_BITS;

  // Counters saturate at 2^31-1
  localparam int COUNT_W = 31;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Default sizes
  localparam int DEF_MAX_ROWS    = 8;
  localparam int DEF_MAX_COLUMNS = 1024;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int CFG_COLS_W = 11;
  localparam int CFG_ROWS_W = 4;
  localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(1024);
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(4);

  // Register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // Sequencer to hash unit
  typedef struct packed {
    logic absorb;     // fold one key byte into every row hash
    logic clear_rem;  // zero the remainders and latch the divisor
    logic step;       // shift one digit of each hash into its remainder
    logic reseed;     // return every row hash to its seed
  } hash_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cms_ram.sv -----
// ----------------------------------------------------------------------------
// cms_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cms_hash.sv -----
// ----------------------------------------------------------------------------
// cms_hash: row hash lanes and digit-serial remainder
// Keeps one 64-bit running hash per row and reduces each hash modulo the
// column count, four bits a cycle, all rows in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_hash #(
  parameter int MAX_ROWS    = cms_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = cms_pkg::DEF_MAX_COLUMNS,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int DW = $clog2(MAX_COLUMNS + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cms_pkg::hash_ctrl_t ctrl_i,
  input  wire logic [7:0]          key_byte_i,
  input  wire logic [DW-1:0]       divisor_i,
  input  wire logic [RW-1:0]       row_sel_i,
  output logic      [CW-1:0]       col_o
);

  localparam int HW = cms_pkg::HASH_W;
  localparam int DB = cms_pkg::DIGIT_BITS;

  logic [HW-1:0] hash_q [MAX_ROWS];
  logic [DW-1:0] rem_q  [MAX_ROWS];
  logic [DW-1:0] div_q;

  // Fold one digit into a remainder: restoring steps, one per bit
  function automatic logic [DW-1:0] rem_step(input logic [DW-1:0] rem,
                                             input logic [DB-1:0] digit,
                                             input logic [DW-1:0] dv);
    logic [DW:0]   t;
    logic [DW-1:0] r;
    r = rem;
    for (int i = DB - 1; i >= 0; i--) begin
      t = {r, digit[i]};
      if (t >= {1'b0, dv}) begin
        t = t - {1'b0, dv};
      end
      r = t[DW-1:0];
    end
    return r;
  endfunction

  // Latch the divisor at key end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear_rem) begin
      div_q <= divisor_i;
    end
  end

  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_lane
    logic [HW-1:0] seed;
    assign seed = HW'(cms_pkg::SEED_BASE + r);

    // Absorb bytes, then shift the hash out a digit at a time
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hash_q[r] <= seed;
      end else if (ctrl_i.reseed) begin
        hash_q[r] <= seed;
      end else if (ctrl_i.absorb) begin
        hash_q[r] <= (hash_q[r] << cms_pkg::SHIFT_MUL) + hash_q[r] + HW'(key_byte_i);
      end else if (ctrl_i.step) begin
        hash_q[r] <= hash_q[r] << DB;
      end
    end

    // Accumulate the remainder, top digit first
    always_ff @(posedge clk_i) begin
      if (ctrl_i.clear_rem) begin
        rem_q[r] <= '0;
      end else if (ctrl_i.step) begin
        rem_q[r] <= rem_step(rem_q[r], hash_q[r][HW-1 -: DB], div_q);
      end
    end
  end

  // Remainder is below the column count, so it fits a column index
  assign col_o = rem_q[row_sel_i][CW-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/count_min_sketch.sv -----
// ----------------------------------------------------------------------------
// count_min_sketch: count-min sketch fed one key byte per beat
// Row hashes absorb key bytes; on the last byte each row's hash modulo the
// column count picks a counter that is incremented (update) or read for the
// minimum (query).
//
//   channel   direction  signals                               handshake
//   key in    in         req_type_i key_byte_i last_byte_i     start / busy
//   estimate  out        estimate_o                            estimate_valid_o
//   config    in/out     paddr pwdata pwrite prdata            psel penable pready
//
// A byte that is not the last of its key is absorbed without raising busy;
// bytes stream back to back. A last byte holds busy through the
// digit-serial remainder (4 hash bits per cycle), then one counter read per
// row through the single read port of the counter RAM, plus the write-back
// and finish cycles. A query's estimate is strobed for one cycle as busy
// falls. After reset busy stays high while the counter RAM is cleared one
// entry a cycle, MAX_ROWS*MAX_COLUMNS entries (8192 by default).
// ----------------------------------------------------------------------------
`default_nettype none

module count_min_sketch #(
  parameter int MAX_ROWS    = cms_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = cms_pkg::DEF_MAX_COLUMNS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // key bytes
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            req_type_i,
  input  wire logic [7:0]                      key_byte_i,
  input  wire logic                            last_byte_i,
  // estimate
  output logic                                 estimate_valid_o,
  output logic [cms_pkg::COUNT_W-1:0]          estimate_o,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [cms_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [cms_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [cms_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int DW    = $clog2(MAX_COLUMNS + 1);
  localparam int SCW   = $clog2(cms_pkg::MOD_STEPS);
  localparam int NW    = cms_pkg::COUNT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RMW
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [cms_pkg::CFG_COLS_W-1:0] cols_cfg_q;
  logic [cms_pkg::CFG_ROWS_W-1:0] rows_cfg_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= cms_pkg::COLS_RESET;
      rows_cfg_q <= cms_pkg::ROWS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        cms_pkg::REG_COLUMNS: cols_cfg_q <= pwdata[cms_pkg::CFG_COLS_W-1:0];
        cms_pkg::REG_ROWS:    rows_cfg_q <= pwdata[cms_pkg::CFG_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Return register contents
  always_comb begin
    case (paddr[2])
      cms_pkg::REG_COLUMNS: prdata = cms_pkg::APB_DATA_W'(cols_cfg_q);
      cms_pkg::REG_ROWS:    prdata = cms_pkg::APB_DATA_W'(rows_cfg_q);
      default:              prdata = '0;
    endcase
  end

  // Clamp the registers to the usable range
  logic [31:0]    cols_raw, rows_raw;
  logic [DW-1:0]  cols_eff;
  logic [RCW-1:0] rows_eff;

  always_comb begin
    cols_raw = 32'(cols_cfg_q);
    if (cols_raw == 32'd0) begin
      cols_raw = 32'd1;
    end else if (cols_raw > 32'(MAX_COLUMNS)) begin
      cols_raw = 32'(MAX_COLUMNS);
    end
    cols_eff = cols_raw[DW-1:0];

    rows_raw = 32'(rows_cfg_q);
    if (rows_raw == 32'd0) begin
      rows_raw = 32'd1;
    end else if (rows_raw > 32'(MAX_ROWS)) begin
      rows_raw = 32'(MAX_ROWS);
    end
    rows_eff = rows_raw[RCW-1:0];
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_e         state_q, state_d;
  logic [AW-1:0]  clr_addr_q, clr_addr_d;
  logic [SCW-1:0] step_cnt_q, step_cnt_d;
  logic [RCW-1:0] rd_row_q, rd_row_d;
  logic [RCW-1:0] rows_q, rows_d;
  logic           query_q, query_d;
  logic           wb_vld_q, wb_vld_d;
  logic [AW-1:0]  wb_addr_q, wb_addr_d;
  logic [NW-1:0]  best_q, best_d;
  logic           est_vld_q, est_vld_d;
  logic [NW-1:0]  est_q, est_d;

  cms_pkg::hash_ctrl_t hctrl;
  logic [CW-1:0]       col;
  logic                accept;
  logic                issue;
  logic [AW-1:0]       rd_addr;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [NW-1:0] ram_wdata, ram_rdata;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start & ~busy;
  assign issue   = (state_q == ST_RMW) && (rd_row_q < rows_q);
  assign rd_addr = AW'(32'(rd_row_q) * MAX_COLUMNS) + AW'(col);

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    step_cnt_d = step_cnt_q;
    rd_row_d   = rd_row_q;
    rows_d     = rows_q;
    query_d    = query_q;
    wb_vld_d   = 1'b0;
    wb_addr_d  = wb_addr_q;
    best_d     = best_q;
    est_vld_d  = 1'b0;
    est_d      = est_q;
    hctrl      = '0;
    ram_we     = 1'b0;
    ram_waddr  = wb_addr_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;

    case (state_q)
      // Sweep the counter RAM to zero
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      // Absorb bytes; on the last one start the reduction
      ST_IDLE: begin
        if (accept) begin
          hctrl.absorb = 1'b1;
          if (last_byte_i) begin
            hctrl.clear_rem = 1'b1;
            query_d    = req_type_i;
            rows_d     = rows_eff;
            best_d     = cms_pkg::COUNT_MAX;
            step_cnt_d = '0;
            state_d    = ST_MOD;
          end
        end
      end

      // Reduce every row hash, then reseed the lanes
      ST_MOD: begin
        hctrl.step = 1'b1;
        step_cnt_d = step_cnt_q + SCW'(1);
        if (step_cnt_q == SCW'(cms_pkg::MOD_STEPS - 1)) begin
          hctrl.reseed = 1'b1;
          rd_row_d     = '0;
          state_d      = ST_RMW;
        end
      end

      // Read one row's counter per cycle, write back (update) or take the minimum (query) the cycle after
      ST_RMW: begin
        if (issue) begin
          ram_re    = 1'b1;
          rd_row_d  = rd_row_q + RCW'(1);
          wb_vld_d  = 1'b1;
          wb_addr_d = rd_addr;
        end
        if (wb_vld_q) begin
          if (query_q) begin
            if (ram_rdata < best_q) begin
              best_d = ram_rdata;
            end
          end else begin
            ram_we    = 1'b1;
            ram_wdata = (ram_rdata == cms_pkg::COUNT_MAX) ? ram_rdata
                                                          : ram_rdata + NW'(1);
          end
        end
        if (!issue && !wb_vld_q) begin
          est_vld_d = query_q;
          est_d     = best_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      step_cnt_q <= '0;
      rd_row_q   <= '0;
      rows_q     <= '0;
      query_q    <= 1'b0;
      wb_vld_q   <= 1'b0;
      est_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      step_cnt_q <= step_cnt_d;
      rd_row_q   <= rd_row_d;
      rows_q     <= rows_d;
      query_q    <= query_d;
      wb_vld_q   <= wb_vld_d;
      est_vld_q  <= est_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wb_addr_q <= wb_addr_d;
    best_q    <= best_d;
    est_q     <= est_d;
  end

  assign estimate_valid_o = est_vld_q;
  assign estimate_o       = est_q;

  // --------------------------------------------------------------------------
  // Row hashes and counter store
  // --------------------------------------------------------------------------
  cms_hash #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (hctrl),
    .key_byte_i (key_byte_i),
    .divisor_i  (cols_eff),
    .row_sel_i  (rd_row_q[RW-1:0]),
    .col_o      (col)
  );

  cms_ram #(
    .WIDTH (NW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A read never hits the entry being written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != rd_addr))
    else $error("counter read and write collide");

  // An estimate only follows a query's read-modify-write pass
  a_est_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    estimate_valid_o |-> ($past(state_q == ST_RMW) && $past(query_q)))
    else $error("estimate without a query");

  // A query never writes the counters
  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW && query_q) |-> !ram_we)
    else $error("query modified a counter");

  // Row walk stays within the rows in use
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW) |-> (rd_row_q <= rows_q))
    else $error("row index past rows in use");

  // No key byte is taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !hctrl.absorb)
    else $error("byte absorbed during clear");

endmodule

`default_nettype wire
